@@ hdl/bmp_row_to_tricolor_bitplanes_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the BMP row to tri-color bitplane converter.
// Each check can be compiled out by defining NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef BMP_ROW_TO_TRICOLOR_BITPLANES_DEFINES_SVH
`define BMP_ROW_TO_TRICOLOR_BITPLANES_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked while out of reset.
`define BMPTRI_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bitplane converter: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define BMPTRI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bitplane converter: next-cycle check failed");

`else

`define BMPTRI_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define BMPTRI_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ hdl/bmptri_pkg.sv @@
// ---------------------------------------------------------------------------
// bmptri_pkg
// Shared types, register codes, thresholds and helpers for the converter.
// ---------------------------------------------------------------------------
package bmptri_pkg;

    // Default sizes.
    localparam int DEF_MAX_ROW_PIXELS  = 1024;
    localparam int DEF_PALETTE_ENTRIES = 256;

    // Pixels handled side by side for one data byte.
    localparam int LANES = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd0;
    localparam logic [1:0] REG_USE_565        = 2'd1;
    localparam logic [1:0] REG_COLOR_ENABLE   = 2'd2;
    localparam logic [1:0] REG_ROW_PIXELS     = 2'd3;

    localparam int CFG_DATA_W = 11;

    // Supported pixel depths.
    localparam logic [4:0] DEPTH_1  = 5'd1;
    localparam logic [4:0] DEPTH_4  = 5'd4;
    localparam logic [4:0] DEPTH_8  = 5'd8;
    localparam logic [4:0] DEPTH_16 = 5'd16;
    localparam logic [4:0] DEPTH_24 = 5'd24;

    // Register reset values.
    localparam logic [4:0]  RST_BITS_PER_PIXEL = DEPTH_24;
    localparam logic        RST_USE_565        = 1'b0;
    localparam logic        RST_COLOR_ENABLE   = 1'b1;
    localparam logic [10:0] RST_ROW_PIXELS     = 11'd640;

    // Classification thresholds.
    localparam logic [7:0] WHITE_LEVEL = 8'h80;
    localparam logic [7:0] COLOR_LEVEL = 8'hF0;
    localparam logic [9:0] SUM_LEVEL   = 10'd384;

    // An accumulator with no pixel cleared.
    localparam logic [7:0] PLANE_WHITE = 8'hFF;

    // Classification of one pixel.
    typedef struct packed {
        logic white;
        logic colored;
    } pix_class_t;

    // Registered palette read data for one data byte.
    typedef struct packed {
        pix_class_t port_a;
        pix_class_t port_b;
        pix_class_t entry0;
        pix_class_t entry1;
        logic       a_ok;
        logic       b_ok;
    } pal_read_t;

    // What one lane did with its pixel.
    typedef struct packed {
        logic       placed;
        logic       emit;
        logic       last;
        logic       mono_clr;
        logic       color_clr;
        logic [2:0] bit_pos;
    } lane_stat_t;

    // One finished pair of plane bytes.
    typedef struct packed {
        logic [7:0] mono;
        logic [7:0] color;
        logic [6:0] position;
        logic       last;
    } plane_result_t;

    // Whitish and colored tests on 8-bit RGB.
    function automatic pix_class_t classify(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic color_on);
        pix_class_t res;
        logic [9:0] sum;
        sum = 10'(r) + 10'(g) + 10'(b);
        if (color_on)
        begin
            res.white = (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
        end
        else
        begin
            res.white = sum > SUM_LEVEL;
        end
        res.colored = (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
        return res;
    endfunction

    // Plane bit for a column within its byte, leftmost pixel in the MSB.
    function automatic logic [7:0] bit_mask(input logic [2:0] pos);
        return 8'h80 >> pos;
    endfunction

endpackage

@@ hdl/bmptri_palette.sv @@
// ---------------------------------------------------------------------------
// bmptri_palette
// Palette classification store with two registered read ports, plus
// dedicated copies of entries 0 and 1 for one-bit pixels.
// ---------------------------------------------------------------------------
module bmptri_palette #(
    parameter int PALETTE_ENTRIES = 256,
    localparam int IW = $clog2(PALETTE_ENTRIES)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [7:0]             wr_index,
    input  bmptri_pkg::pix_class_t wr_class,
    input  logic                   rd_en,
    input  logic [7:0]             rd_index_a,
    input  logic [7:0]             rd_index_b,
    output bmptri_pkg::pal_read_t  rd_data
);
    import bmptri_pkg::*;

    pix_class_t mem [PALETTE_ENTRIES];
    pix_class_t entry0_reg;
    pix_class_t entry1_reg;
    pal_read_t  rd_reg;

    logic wr_ok;
    logic a_ok;
    logic b_ok;

    // Indexes past the palette are dropped on load and read as black.
    assign wr_ok = {1'b0, wr_index} < 9'(PALETTE_ENTRIES);
    assign a_ok  = {1'b0, rd_index_a} < 9'(PALETTE_ENTRIES);
    assign b_ok  = {1'b0, rd_index_b} < 9'(PALETTE_ENTRIES);

    // Entry loads.
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
        begin
            mem[wr_index[IW-1:0]] <= wr_class;
            if (wr_index == 8'd0)
            begin
                entry0_reg <= wr_class;
            end
            if (wr_index == 8'd1)
            begin
                entry1_reg <= wr_class;
            end
        end
    end

    // Reads for an accepted data byte.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg.port_a <= mem[rd_index_a[IW-1:0]];
            rd_reg.port_b <= mem[rd_index_b[IW-1:0]];
            rd_reg.entry0 <= entry0_reg;
            rd_reg.entry1 <= entry1_reg;
            rd_reg.a_ok   <= a_ok;
            rd_reg.b_ok   <= b_ok;
        end
    end

    assign rd_data = rd_reg;

endmodule

@@ hdl/bmptri_lane.sv @@
// ---------------------------------------------------------------------------
// bmptri_lane
// Places one pixel of a data byte: column, kept or clipped, plane bit and
// whether it completes a plane byte.
// ---------------------------------------------------------------------------
module bmptri_lane #(
    parameter int MAX_ROW_PIXELS = 1024,
    localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
    input  logic [2:0]             lane_offset,
    input  logic [CW-1:0]          start_col,
    input  logic [CW-1:0]          width,
    input  logic [3:0]             pix_count,
    input  bmptri_pkg::pix_class_t pix,
    input  logic                   color_on,
    output bmptri_pkg::lane_stat_t stat
);
    import bmptri_pkg::*;

    logic [CW:0] col;
    logic [CW:0] col_after;
    logic        placed;

    assign col       = {1'b0, start_col} + (CW+1)'(lane_offset);
    assign col_after = col + (CW+1)'(1);

    // The pixel exists in this byte and its column lies inside the row.
    assign placed = ({1'b0, lane_offset} < pix_count) && (col < {1'b0, width});

    // Byte complete on an eight-pixel boundary or at the row's last pixel.
    always_comb
    begin
        stat.placed    = placed;
        stat.emit      = placed && ((col_after[2:0] == 3'd0) || (col_after == {1'b0, width}));
        stat.last      = placed && (col_after == {1'b0, width});
        stat.mono_clr  = placed && !pix.white && !(pix.colored && color_on);
        stat.color_clr = placed && !pix.white && pix.colored && color_on;
        stat.bit_pos   = col[2:0];
    end

endmodule

@@ hdl/bmptri_merge.sv @@
// ---------------------------------------------------------------------------
// bmptri_merge
// Combines the lane results into the plane accumulators, forms the output
// byte and applies the end-of-row flush and clear.
// ---------------------------------------------------------------------------
module bmptri_merge #(
    parameter int MAX_ROW_PIXELS = 1024,
    localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
    input  bmptri_pkg::lane_stat_t [bmptri_pkg::LANES-1:0] lanes,
    input  logic [CW-1:0]             col,
    input  logic [CW-1:0]             width,
    input  logic [7:0]                mono,
    input  logic [7:0]                color,
    input  logic [6:0]                pos,
    input  logic                      row_end,
    output logic                      emit,
    output bmptri_pkg::plane_result_t result,
    output logic [CW-1:0]             col_next,
    output logic [7:0]                mono_next,
    output logic [7:0]                color_next,
    output logic [6:0]                pos_next
);
    import bmptri_pkg::*;

    logic [7:0]    clr_mono_a;
    logic [7:0]    clr_mono_b;
    logic [7:0]    clr_color_a;
    logic [7:0]    clr_color_b;
    logic          seen;
    logic [1:0]    n_emit;
    logic          emit_last;
    logic [3:0]    placed_cnt;
    logic [7:0]    mono_a;
    logic [7:0]    mono_b;
    logic [7:0]    color_a;
    logic [7:0]    color_b;
    logic [CW-1:0] col_step;
    logic [7:0]    mono_step;
    logic [7:0]    color_step;
    logic [6:0]    pos_step;
    logic          emit_step;
    plane_result_t result_step;

    // Lanes before the first completed byte go into the current
    // accumulators, lanes after it into fresh ones.
    always_comb
    begin
        clr_mono_a  = '0;
        clr_mono_b  = '0;
        clr_color_a = '0;
        clr_color_b = '0;
        seen        = 1'b0;
        n_emit      = '0;
        emit_last   = 1'b0;
        placed_cnt  = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (lanes[k].placed)
            begin
                placed_cnt = placed_cnt + 4'd1;
            end
            if (!seen)
            begin
                if (lanes[k].mono_clr)
                begin
                    clr_mono_a = clr_mono_a | bit_mask(lanes[k].bit_pos);
                end
                if (lanes[k].color_clr)
                begin
                    clr_color_a = clr_color_a | bit_mask(lanes[k].bit_pos);
                end
            end
            else
            begin
                if (lanes[k].mono_clr)
                begin
                    clr_mono_b = clr_mono_b | bit_mask(lanes[k].bit_pos);
                end
                if (lanes[k].color_clr)
                begin
                    clr_color_b = clr_color_b | bit_mask(lanes[k].bit_pos);
                end
            end
            if (lanes[k].emit)
            begin
                seen      = 1'b1;
                n_emit    = n_emit + 2'd1;
                emit_last = lanes[k].last;
            end
        end
    end

    assign mono_a   = mono & ~clr_mono_a;
    assign color_a  = color & ~clr_color_a;
    assign mono_b   = ~clr_mono_b;
    assign color_b  = ~clr_color_b;
    assign col_step = col + CW'(placed_cnt);

    // Result of placing the byte's pixels. A byte that straddles a boundary
    // and then reaches the row end completes two plane bytes; the later one
    // is the one delivered.
    always_comb
    begin
        case (n_emit)
            2'd0:
            begin
                emit_step   = 1'b0;
                result_step = '{mono: mono_a, color: color_a, position: pos, last: 1'b0};
                mono_step   = mono_a;
                color_step  = color_a;
                pos_step    = pos;
            end
            2'd1:
            begin
                emit_step   = 1'b1;
                result_step = '{mono: mono_a, color: color_a, position: pos, last: emit_last};
                mono_step   = mono_b;
                color_step  = color_b;
                pos_step    = pos + 7'd1;
            end
            2'd2:
            begin
                emit_step   = 1'b1;
                result_step = '{mono: mono_b, color: color_b, position: pos + 7'd1,
                                last: emit_last};
                mono_step   = PLANE_WHITE;
                color_step  = PLANE_WHITE;
                pos_step    = pos + 7'd2;
            end
            default:
            begin
                emit_step   = 1'b0;
                result_step = '{mono: mono_a, color: color_a, position: pos, last: 1'b0};
                mono_step   = mono_a;
                color_step  = color_a;
                pos_step    = pos;
            end
        endcase
    end

    // End of row: mark the last byte, flush a partly filled byte, clear.
    always_comb
    begin
        emit       = emit_step;
        result     = result_step;
        col_next   = col_step;
        mono_next  = mono_step;
        color_next = color_step;
        pos_next   = pos_step;
        if (row_end)
        begin
            if (emit_step)
            begin
                result.last = 1'b1;
            end
            else if ((col_step < width) && (col_step[2:0] != 3'd0))
            begin
                emit   = 1'b1;
                result = '{mono: mono_step, color: color_step, position: pos_step,
                           last: 1'b1};
            end
            col_next   = '0;
            mono_next  = PLANE_WHITE;
            color_next = PLANE_WHITE;
            pos_next   = '0;
        end
    end

endmodule

@@ hdl/bmp_row_to_tricolor_bitplanes.sv @@
// ---------------------------------------------------------------------------
// bmp_row_to_tricolor_bitplanes: BMP row bytes to black and color bitplanes.
// Data bytes are registered in the input stage, plane bytes in the output register.
// Throughput: one byte per cycle when not stalled; 8 lanes place its pixels at once.
// Reset restores register defaults and clears row state; palette is undefined.
// ---------------------------------------------------------------------------
`include "bmp_row_to_tricolor_bitplanes_defines.svh"

module bmp_row_to_tricolor_bitplanes #(
    parameter int MAX_ROW_PIXELS  = bmptri_pkg::DEF_MAX_ROW_PIXELS,
    parameter int PALETTE_ENTRIES = bmptri_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration writes.
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [bmptri_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          mode,
    input  logic [7:0]                    data_byte,
    input  logic [7:0]                    entry_index,
    input  logic [7:0]                    entry_red,
    input  logic [7:0]                    entry_green,
    input  logic [7:0]                    entry_blue,
    input  logic                          row_end,
    // Plane bytes.
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [7:0]                    mono_plane_byte,
    output logic [7:0]                    color_plane_byte,
    output logic [6:0]                    byte_position,
    output logic                          row_last
);
    import bmptri_pkg::*;

    localparam int CW = $clog2(MAX_ROW_PIXELS + 1);

    // Configuration registers.
    logic [4:0]  bpp_reg;
    logic        use_565_reg;
    logic        color_enable_reg;
    logic [10:0] row_pixels_reg;

    // Stage after input transfer.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_row_end_reg;

    // Row state.
    logic [CW-1:0] col_reg;
    logic [7:0]    mono_reg;
    logic [7:0]    color_reg;
    logic [6:0]    pos_reg;
    logic [15:0]   part_reg;
    logic [1:0]    pcnt_reg;

    // Output register.
    logic          res_valid_reg;
    plane_result_t res_reg;

    logic          accept;
    logic          s1_go;
    logic          color_on;
    logic [CW-1:0] width;
    pix_class_t    load_class;
    pal_read_t     pal;
    logic [7:0]    rd_index_a;
    logic [7:0]    rd_index_b;

    pix_class_t [LANES-1:0] lane_pix;
    lane_stat_t [LANES-1:0] lane_stat;
    logic [3:0]             lane_count;
    logic [15:0]            part_step;
    logic [1:0]             pcnt_step;
    logic [7:0]             r16;
    logic [7:0]             g16;
    logic [7:0]             b16;

    logic          m_emit;
    plane_result_t m_result;
    logic [CW-1:0] m_col_next;
    logic [7:0]    m_mono_next;
    logic [7:0]    m_color_next;
    logic [6:0]    m_pos_next;

    // Handshake: the stage advances when the output register is free or
    // being emptied in the same cycle.
    assign s1_go      = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_go;
    assign accept     = item_valid && !item_stall;

    assign color_on = color_enable_reg && (bpp_reg != DEPTH_1);

    // Kept row width, saturated at the row buffer size.
    always_comb
    begin
        if (32'(row_pixels_reg) > 32'(MAX_ROW_PIXELS))
        begin
            width = CW'(MAX_ROW_PIXELS);
        end
        else
        begin
            width = CW'(row_pixels_reg);
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg          <= RST_BITS_PER_PIXEL;
            use_565_reg      <= RST_USE_565;
            color_enable_reg <= RST_COLOR_ENABLE;
            row_pixels_reg   <= RST_ROW_PIXELS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BITS_PER_PIXEL: bpp_reg          <= cfg_data[4:0];
                REG_USE_565:        use_565_reg      <= cfg_data[0];
                REG_COLOR_ENABLE:   color_enable_reg <= cfg_data[0];
                REG_ROW_PIXELS:     row_pixels_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Palette: classify at load time, read for a transferred data byte.
    assign load_class = classify(entry_red, entry_green, entry_blue, color_on);
    assign rd_index_a = (bpp_reg == DEPTH_4) ? {4'h0, data_byte[7:4]} : data_byte;
    assign rd_index_b = {4'h0, data_byte[3:0]};

    bmptri_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .clk       (clk),
        .wr_en     (accept && !mode),
        .wr_index  (entry_index),
        .wr_class  (load_class),
        .rd_en     (accept && mode),
        .rd_index_a(rd_index_a),
        .rd_index_b(rd_index_b),
        .rd_data   (pal)
    );

    // Data bytes enter the stage; palette loads finish at transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && mode)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mode)
        begin
            s1_byte_reg    <= data_byte;
            s1_row_end_reg <= row_end;
        end
    end

    // 16-bit pixel unpack: stored byte is the low byte.
    always_comb
    begin
        b16 = {part_reg[4:0], 3'b000};
        if (use_565_reg)
        begin
            g16 = {s1_byte_reg[2:0], part_reg[7:5], 2'b00};
            r16 = {s1_byte_reg[7:3], 3'b000};
        end
        else
        begin
            g16 = {s1_byte_reg[1:0], part_reg[7:5], 3'b000};
            r16 = {s1_byte_reg[6:2], 3'b000};
        end
    end

    // Per-depth pixel classes for the lanes and byte gathering.
    always_comb
    begin
        lane_pix   = '0;
        lane_count = 4'd0;
        part_step  = part_reg;
        pcnt_step  = pcnt_reg;
        case (bpp_reg)
            DEPTH_1:
            begin
                lane_count = 4'd8;
                for (int k = 0; k < LANES; k++)
                begin
                    lane_pix[k] = s1_byte_reg[7-k] ? pal.entry1 : pal.entry0;
                end
            end
            DEPTH_4:
            begin
                lane_count  = 4'd2;
                lane_pix[0] = pal.a_ok ? pal.port_a : '0;
                lane_pix[1] = pal.b_ok ? pal.port_b : '0;
            end
            DEPTH_8:
            begin
                lane_count  = 4'd1;
                lane_pix[0] = pal.a_ok ? pal.port_a : '0;
            end
            DEPTH_16:
            begin
                if (pcnt_reg == 2'd0)
                begin
                    part_step = {8'h00, s1_byte_reg};
                    pcnt_step = 2'd1;
                end
                else
                begin
                    pcnt_step   = 2'd0;
                    lane_count  = 4'd1;
                    lane_pix[0] = classify(r16, g16, b16, color_on);
                end
            end
            DEPTH_24:
            begin
                if (pcnt_reg == 2'd0)
                begin
                    part_step = {8'h00, s1_byte_reg};
                    pcnt_step = 2'd1;
                end
                else if (pcnt_reg == 2'd1)
                begin
                    part_step = {s1_byte_reg, part_reg[7:0]};
                    pcnt_step = 2'd2;
                end
                else
                begin
                    pcnt_step   = 2'd0;
                    lane_count  = 4'd1;
                    lane_pix[0] = classify(s1_byte_reg, part_reg[15:8], part_reg[7:0],
                                           color_on);
                end
            end
            default:
            begin
                lane_count = 4'd0;
            end
        endcase
    end

    // Eight placement lanes.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        bmptri_lane #(
            .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
        ) u_lane (
            .lane_offset(3'(k)),
            .start_col  (col_reg),
            .width      (width),
            .pix_count  (lane_count),
            .pix        (lane_pix[k]),
            .color_on   (color_on),
            .stat       (lane_stat[k])
        );
    end

    bmptri_merge #(
        .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
    ) u_merge (
        .lanes     (lane_stat),
        .col       (col_reg),
        .width     (width),
        .mono      (mono_reg),
        .color     (color_reg),
        .pos       (pos_reg),
        .row_end   (s1_row_end_reg),
        .emit      (m_emit),
        .result    (m_result),
        .col_next  (m_col_next),
        .mono_next (m_mono_next),
        .color_next(m_color_next),
        .pos_next  (m_pos_next)
    );

    // Row state update when the stage advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            mono_reg  <= PLANE_WHITE;
            color_reg <= PLANE_WHITE;
            pos_reg   <= '0;
            part_reg  <= '0;
            pcnt_reg  <= '0;
        end
        else if (s1_go)
        begin
            col_reg   <= m_col_next;
            mono_reg  <= m_mono_next;
            color_reg <= m_color_next;
            pos_reg   <= m_pos_next;
            if (s1_row_end_reg)
            begin
                part_reg <= '0;
                pcnt_reg <= '0;
            end
            else if (col_reg < width)
            begin
                part_reg <= part_step;
                pcnt_reg <= pcnt_step;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go && m_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && m_emit)
        begin
            res_reg <= m_result;
        end
    end

    assign result_valid     = res_valid_reg;
    assign mono_plane_byte  = res_reg.mono;
    assign color_plane_byte = res_reg.color;
    assign byte_position    = res_reg.position;
    assign row_last         = res_reg.last;

    // The byte gather count only takes the values 0, 1 and 2.
    `BMPTRI_ASSERT_IMPLY(a_pcnt_range, clk, rst_n, 1'b1, pcnt_reg != 2'd3)

    // A cleared plane bit is pending only inside a partly filled byte.
    `BMPTRI_ASSERT_IMPLY(a_pending_bits, clk, rst_n, (mono_reg != PLANE_WHITE) || (color_reg != PLANE_WHITE), col_reg[2:0] != 3'd0)

    // Finishing a row-end byte leaves the row state cleared.
    `BMPTRI_ASSERT_NEXT(a_row_end_clear, clk, rst_n, s1_go && s1_row_end_reg, (col_reg == '0) && (pos_reg == '0) && (pcnt_reg == '0))

endmodule
